// ===== src/urc_pkg.sv =====
package urc_pkg;

  // Field widths fixed by the register map and the result format.
  localparam int TIMEOUT_W = 17;
  localparam int TRIG_W    = 8;
  localparam int SCALE_W   = 16;
  localparam int PULSE_W   = 17;
  localparam int DIST_W    = 25;
  localparam int CFG_W     = 17;
  localparam int IDX_W     = 2;

  localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

  // Register indexes on the write port.
  localparam logic [IDX_W-1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_TRIG_LOW  = 2'd1;
  localparam logic [IDX_W-1:0] REG_TRIG_HIGH = 2'd2;
  localparam logic [IDX_W-1:0] REG_SCALE     = 2'd3;

  // Queue sizes; both must be powers of two.
  localparam int FQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic start_req;
    logic echo;
  } item_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout;
    logic [TRIG_W-1:0]    trig_low;
    logic [TRIG_W-1:0]    trig_high;
    logic [SCALE_W-1:0]   scale;
  } cfg_t;

  typedef struct packed {
    logic               trigger;
    logic               busy;
    logic               done;
    logic               timed_out;
    logic [PULSE_W-1:0] pulse;
  } step_t;

  typedef struct packed {
    step_t             step;
    logic [DIST_W-1:0] distance;
  } result_t;

endpackage

// ===== src/urc_fifo.sv =====
module urc_fifo import urc_pkg::*; #(
  parameter int  DEPTH = 2,
  parameter type T     = item_t
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  T                           din,
  output logic                       full,
  input  logic                       pop,
  output T                           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);

  T              mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Storage; pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill level above depth");

endmodule

// ===== src/urc_seq.sv =====
module urc_seq import urc_pkg::*; #(
  parameter int COUNTER_BITS = 17
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output logic  step_valid,
  output step_t step
);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
  localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
  localparam logic [2:0] PH_WAIT_RISE = 3'd3;
  localparam logic [2:0] PH_MEASURE   = 3'd4;

  localparam int          CB   = COUNTER_BITS;
  localparam logic [32:0] CMAX = (33'(1) << CB) - 33'(1);

  logic [2:0]         phase;
  logic [2:0]         phase_next;
  logic [CB-1:0]      tick_count;
  logic [CB-1:0]      tick_count_next;
  logic [CB-1:0]      tick_inc;
  logic               timeout_seen;
  logic               timeout_seen_next;
  logic [PULSE_W-1:0] last_pulse;
  logic [PULSE_W-1:0] last_pulse_next;
  logic [PULSE_W-1:0] pulse_sat;
  logic [32:0]        tmo_wide;
  logic [CB-1:0]      tmo;
  logic               done;

  // Effective timeout: at least one tick, at most what the counter holds.
  always_comb begin
    tmo_wide = 33'(cfg.timeout);
    if (tmo_wide == '0) begin
      tmo_wide = 33'(1);
    end
    if (tmo_wide > CMAX) begin
      tmo_wide = CMAX;
    end
    tmo = tmo_wide[CB-1:0];
  end

  assign tick_inc  = tick_count + CB'(1);
  assign pulse_sat = (33'(tick_count) > 33'(PULSE_MAX)) ? PULSE_MAX
                                                       : PULSE_W'(tick_count);

  // Phase sequencer, advanced once per request.
  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    timeout_seen_next = timeout_seen;
    last_pulse_next   = last_pulse;
    done              = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (item.start_req) begin
          tick_count_next   = '0;
          timeout_seen_next = 1'b0;
          phase_next        = (cfg.trig_low != '0) ? PH_TRIG_LOW : PH_TRIG_HIGH;
        end
      end
      PH_TRIG_LOW: begin
        if (33'(tick_inc) >= 33'(cfg.trig_low)) begin
          tick_count_next = '0;
          phase_next      = PH_TRIG_HIGH;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_TRIG_HIGH: begin
        if (33'(tick_inc) >= 33'(cfg.trig_high)) begin
          tick_count_next = '0;
          phase_next      = PH_WAIT_RISE;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_WAIT_RISE: begin
        if (item.echo) begin
          tick_count_next = CB'(1);
          phase_next      = PH_MEASURE;
        end else if (tick_inc >= tmo) begin
          timeout_seen_next = 1'b1;
          tick_count_next   = '0;
          phase_next        = PH_MEASURE;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_MEASURE: begin
        if (!item.echo || tick_count >= tmo) begin
          // The pulse ends on a low sample, or on the timeout while still high.
          if (item.echo) begin
            timeout_seen_next = 1'b1;
          end
          last_pulse_next = pulse_sat;
          tick_count_next = '0;
          phase_next      = PH_IDLE;
          done            = 1'b1;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase
  end

  // State and the per-tick status record.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      timeout_seen <= 1'b0;
      last_pulse   <= '0;
      step_valid   <= 1'b0;
    end else begin
      step_valid <= fire;
      if (fire) begin
        phase        <= phase_next;
        tick_count   <= tick_count_next;
        timeout_seen <= timeout_seen_next;
        last_pulse   <= last_pulse_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      step.trigger   <= (phase_next == PH_TRIG_HIGH);
      step.busy      <= (phase_next != PH_IDLE);
      step.done      <= done;
      step.timed_out <= timeout_seen_next;
      step.pulse     <= last_pulse_next;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step_valid && step.done |-> !step.busy)
    else $error("finished measurement still reported busy");

  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    step_valid && step.trigger |-> step.busy)
    else $error("trigger driven outside a measurement");

endmodule

// ===== src/urc_range.sv =====
module urc_range import urc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_valid,
  input  step_t              step,
  input  logic [SCALE_W-1:0] scale,
  output result_t            result
);

  logic [PULSE_W+SCALE_W-1:0] product;
  logic [DIST_W-1:0]          dist_new;
  logic [DIST_W-1:0]          last_distance;

  // Distance in 1/256 cm; the product of the field maxima fits in 33 bits, so its upper 25 bits lose nothing.
  assign product  = (PULSE_W+SCALE_W)'(step.pulse) * (PULSE_W+SCALE_W)'(scale);
  assign dist_new = product[8 +: DIST_W];

  assign result.step     = step;
  assign result.distance = step.done ? dist_new : last_distance;

  // The distance is held between measurements.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_distance <= '0;
    end else if (step_valid && step.done) begin
      last_distance <= dist_new;
    end
  end

endmodule

// ===== src/ultrasonic_range_controller_unit.sv =====
// Ultrasonic ranging controller for an HC-SR04 style sensor. Push one request
// per microsecond tick (start_req, sampled echo) and pop exactly one status
// result per request, in order: trigger level, busy, a one-tick done flag,
// the timeout flag, and the held pulse length and distance in 1/256 cm. The
// block sustains one request per clock cycle while a result slot is free; a
// request passes from a two-entry request queue through the phase sequencer
// register and the range multiplier into a four-entry result queue. full
// rises only when results are not popped. Write the registers only while no
// requests or results are outstanding.
module ultrasonic_range_controller_unit import urc_pkg::*; #(
  parameter int COUNTER_BITS = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                start_req,
  input  logic                echo,
  output logic                empty,
  input  logic                pop,
  output logic                trigger,
  output logic                busy_res,
  output logic                done_res,
  output logic                timed_out,
  output logic [PULSE_W-1:0]  pulse_ticks,
  output logic [DIST_W-1:0]   distance_q8,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_index,
  input  logic [CFG_W-1:0]    wr_data
);

  cfg_t    cfg;
  item_t   fq_din;
  item_t   fq_dout;
  logic    fq_empty;
  logic    fire;
  logic    step_valid;
  step_t   step;
  result_t range_res;
  result_t oq_dout;
  logic    oq_full;
  logic [$clog2(FQ_DEPTH+1)-1:0] fq_count;
  logic [OQ_CW-1:0] oq_count;
  logic [OQ_CW-1:0] in_flight;

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout   <= TIMEOUT_W'(100000);
      cfg.trig_low  <= TRIG_W'(5);
      cfg.trig_high <= TRIG_W'(10);
      cfg.scale     <= SCALE_W'(1114);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TIMEOUT:   cfg.timeout   <= wr_data[TIMEOUT_W-1:0];
        REG_TRIG_LOW:  cfg.trig_low  <= wr_data[TRIG_W-1:0];
        REG_TRIG_HIGH: cfg.trig_high <= wr_data[TRIG_W-1:0];
        REG_SCALE:     cfg.scale     <= wr_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: request queue.
  assign fq_din.start_req = start_req;
  assign fq_din.echo      = echo;

  urc_fifo #(.DEPTH(FQ_DEPTH), .T(item_t)) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (fq_din),
    .full  (full),
    .pop   (fire),
    .dout  (fq_dout),
    .empty (fq_empty),
    .count (fq_count)
  );

  // A request advances only when a result slot is reserved for it.
  assign in_flight = oq_count + OQ_CW'(step_valid);
  assign fire      = !fq_empty && (in_flight < OQ_CW'(OQ_DEPTH));

  urc_seq #(.COUNTER_BITS(COUNTER_BITS)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (fq_dout),
    .cfg        (cfg),
    .step_valid (step_valid),
    .step       (step)
  );

  urc_range u_range (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .step       (step),
    .scale      (cfg.scale),
    .result     (range_res)
  );

  // Back: result queue.
  urc_fifo #(.DEPTH(OQ_DEPTH), .T(result_t)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (step_valid),
    .din   (range_res),
    .full  (oq_full),
    .pop   (pop),
    .dout  (oq_dout),
    .empty (empty),
    .count (oq_count)
  );

  assign trigger     = oq_dout.step.trigger;
  assign busy_res    = oq_dout.step.busy;
  assign done_res    = oq_dout.step.done;
  assign timed_out   = oq_dout.step.timed_out;
  assign pulse_ticks = oq_dout.step.pulse;
  assign distance_q8 = oq_dout.distance;

  a_no_result_drop: assert property (@(posedge clk) disable iff (rst)
    step_valid |-> !oq_full)
    else $error("result produced with no free result slot");

  a_fire_slot: assert property (@(posedge clk) disable iff (rst)
    fire |-> oq_count != OQ_CW'(OQ_DEPTH))
    else $error("request advanced while result queue full");

  a_full_level: assert property (@(posedge clk) disable iff (rst)
    full |-> fq_count == $bits(fq_count)'(FQ_DEPTH))
    else $error("request queue reports full below its depth");

endmodule
